>>> rtl/rbst_pkg.sv
package rbst_pkg;

   // field widths
   localparam int COORD_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int DIR_W      = 18;
   localparam int DIST_W     = 31;
   localparam int THR_W      = 16;
   localparam int TAG_W      = 16;
   localparam int AXIS_W     = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // |box - origin| scaled by 2^16, and the signed slab distance
   localparam int NUM_W = COORD_W + FRAC_W;
   localparam int DEN_W = DIR_W;
   localparam int T_W   = NUM_W + 1;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X           = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y           = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z           = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X              = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y              = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z              = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE       = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_PARALLEL_THRESHOLD = CSR_IDX_W'(7);

   // reset values
   localparam logic [DIR_W-1:0]  ONE_Q16        = DIR_W'(65536);
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = {DIST_W{1'b1}};
   localparam logic [THR_W-1:0]  THR_RESET      = THR_W'(1);

   // face normal axis codes
   localparam logic [AXIS_W-1:0] AXIS_X    = AXIS_W'(0);
   localparam logic [AXIS_W-1:0] AXIS_Y    = AXIS_W'(1);
   localparam logic [AXIS_W-1:0] AXIS_Z    = AXIS_W'(2);
   localparam logic [AXIS_W-1:0] AXIS_NONE = AXIS_W'(3);

   typedef struct packed {
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
      logic [TAG_W-1:0]          box_tag;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] entry_distance;
      logic [AXIS_W-1:0] normal_axis;
      logic              normal_positive;
      logic [TAG_W-1:0]  result_tag;
   } rsp_type;

endpackage

>>> rtl/rbst_div_pipe.sv
// Pipelined unsigned restoring divider, STEP_BITS quotient bits per stage.
module rbst_div_pipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 18,
   parameter int STEP_BITS = 4,
   localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS
) (
   input  logic              clock,
   input  logic [STAGES-1:0] load,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [NUM_W-1:0]  quo
);

   localparam int PAD_W = STAGES * STEP_BITS;

   // word holds the numerator bits still to go on top, quotient bits below
   logic [DEN_W-1:0] rem_ff  [STAGES];
   logic [DEN_W-1:0] rem_in  [STAGES];
   logic [PAD_W-1:0] word_ff [STAGES];
   logic [PAD_W-1:0] word_in [STAGES];

   genvar s;
   for (s = 0; s < STAGES; s++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [PAD_W-1:0] word_src;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign word_src = PAD_W'(num);
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign word_src = word_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0]   part;
         logic [DEN_W-1:0] rem;
         logic [PAD_W-1:0] word;
         rem  = rem_src;
         word = word_src;
         part = '0;
         for (int b = 0; b < STEP_BITS; b++) begin
            part = {rem, word[PAD_W-1]};
            word = word << 1;
            if (part >= {1'b0, den}) begin
               part    = part - {1'b0, den};
               word[0] = 1'b1;
            end
            rem = part[DEN_W-1:0];
         end
         rem_in[s]  = rem;
         word_in[s] = word;
      end

      always_ff @(posedge clock) begin
         if (load[s]) begin
            rem_ff[s]  <= rem_in[s];
            word_ff[s] <= word_in[s];
         end
      end
   end

   assign quo = word_ff[STAGES-1][NUM_W-1:0];

endmodule

>>> rtl/ray_box_slab_test.sv
// Ray / axis-aligned box slab test, one box beat per cycle sustained while the
// result side does not stall; the depth follows DIV_BITS through the six slab dividers.
// A stalled result holds its own stage and every full stage behind it.
// Reset (synchronous, active high) empties the pipeline and loads the default
// ray: origin 0, direction +x, max distance 2^31-1, parallel threshold 1.
module ray_box_slab_test
   import rbst_pkg::*;
#(
   parameter int DIV_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Stage map:
   //   CAP   box corner minus origin (33-bit signed differences)
   //   ABS   magnitude << 16 into the dividers, parallel-slab check
   //   DIV   DIV_ST stages of the six dividers (|diff| * 2^16 / |dir|)
   //   SIGN  quotient sign restored, truncated toward zero
   //   SWAP  near/far ordering per axis, flip gives face sign
   //   X,Y,Z interval narrowing one axis per stage; Z also formats the beat
   localparam int DIV_ST = (NUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int S_CAP  = 0;
   localparam int S_ABS  = S_CAP + 1;
   localparam int S_DIV0 = S_ABS + 1;
   localparam int S_SIGN = S_DIV0 + DIV_ST;
   localparam int S_SWAP = S_SIGN + 1;
   localparam int S_X    = S_SWAP + 1;
   localparam int S_Y    = S_X + 1;
   localparam int S_Z    = S_Y + 1;
   localparam int NUM_ST = S_Z + 1;

   typedef logic signed [T_W-1:0] dist_type;

   // sideband that rides alongside the dividers
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [2:0]       neg_lo;
      logic [2:0]       neg_hi;
      logic [2:0]       pmiss;
   } sb_type;

   // running slab interval plus per-axis near/far distances
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic              hit;
      dist_type          entry;
      dist_type          exit_t;
      logic [AXIS_W-1:0] axis;
      logic              pos;
      dist_type [2:0]    near_t;
      dist_type [2:0]    far_t;
      logic [2:0]        flip;
      logic [2:0]        pmiss;
   } walk_type;

   // ---------------------------------------------------------------------
   // Configuration registers. Direction is kept as sign + magnitude, which
   // is what the dividers and the parallel test want.
   // ---------------------------------------------------------------------
   logic signed [COORD_W-1:0] origin_ff [3];
   logic [2:0]                dir_neg_ff;
   logic [DIR_W-1:0]          dir_mag_ff [3];
   logic [DIST_W-1:0]         max_dist_ff;
   logic [THR_W-1:0]          thr_ff;
   logic [DIR_W-1:0]          wr_dir_mag;

   assign csr_ready  = 1'b1;
   assign wr_dir_mag = csr_data[DIR_W-1] ? DIR_W'(~csr_data[DIR_W-1:0] + 1'b1)
                                         : csr_data[DIR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0]  <= '0;
         origin_ff[1]  <= '0;
         origin_ff[2]  <= '0;
         dir_neg_ff    <= '0;
         dir_mag_ff[0] <= ONE_Q16;
         dir_mag_ff[1] <= '0;
         dir_mag_ff[2] <= '0;
         max_dist_ff   <= MAX_DIST_RESET;
         thr_ff        <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_ff[0] <= $signed(csr_data);
            CSR_ORIGIN_Y: origin_ff[1] <= $signed(csr_data);
            CSR_ORIGIN_Z: origin_ff[2] <= $signed(csr_data);
            CSR_DIR_X: begin
               dir_neg_ff[0] <= csr_data[DIR_W-1];
               dir_mag_ff[0] <= wr_dir_mag;
            end
            CSR_DIR_Y: begin
               dir_neg_ff[1] <= csr_data[DIR_W-1];
               dir_mag_ff[1] <= wr_dir_mag;
            end
            CSR_DIR_Z: begin
               dir_neg_ff[2] <= csr_data[DIR_W-1];
               dir_mag_ff[2] <= wr_dir_mag;
            end
            CSR_MAX_DISTANCE:       max_dist_ff <= csr_data[DIST_W-1:0];
            CSR_PARALLEL_THRESHOLD: thr_ff      <= csr_data[THR_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // An axis is parallel when its direction is zero or its magnitude is
   // under the threshold. The user must keep config static while beats are in
   // flight (the block does not enforce it), so this is read live by the stage that needs it.
   logic [2:0] axis_par;
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         axis_par[a] = (dir_mag_ff[a] == '0) || (dir_mag_ff[a] < DIR_W'(thr_ff));
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: one valid bit per stage. A stage loads when it is
   // empty or its successor is loading, so bubbles close up under a stall
   // and the input keeps flowing while the output beat waits, until no bubble is left.
   // ---------------------------------------------------------------------
   logic [NUM_ST-1:0] valid_ff;
   logic [NUM_ST-1:0] ready;

   always_comb begin
      ready[NUM_ST-1] = !valid_ff[NUM_ST-1] || !rsp_stall;
      for (int k = NUM_ST - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[S_CAP]) valid_ff[S_CAP] <= req_valid;
         for (int k = S_CAP + 1; k < NUM_ST; k++) begin
            if (ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_stall = !ready[S_CAP];
   assign rsp_valid = valid_ff[NUM_ST-1];

   // ---------------------------------------------------------------------
   // CAP: box corner minus origin, exact in 33 bits
   // ---------------------------------------------------------------------
   logic signed [COORD_W-1:0] box_lo [3];
   logic signed [COORD_W-1:0] box_hi [3];
   logic signed [COORD_W:0]   cap_lo_ff [3];
   logic signed [COORD_W:0]   cap_hi_ff [3];
   logic [TAG_W-1:0]          cap_tag_ff;

   always_comb begin
      box_lo[0] = req_data.box_min_x;
      box_lo[1] = req_data.box_min_y;
      box_lo[2] = req_data.box_min_z;
      box_hi[0] = req_data.box_max_x;
      box_hi[1] = req_data.box_max_y;
      box_hi[2] = req_data.box_max_z;
   end

   always_ff @(posedge clock) begin
      if (ready[S_CAP]) begin
         for (int a = 0; a < 3; a++) begin
            cap_lo_ff[a] <= {box_lo[a][COORD_W-1], box_lo[a]}
                          - {origin_ff[a][COORD_W-1], origin_ff[a]};
            cap_hi_ff[a] <= {box_hi[a][COORD_W-1], box_hi[a]}
                          - {origin_ff[a][COORD_W-1], origin_ff[a]};
         end
         cap_tag_ff <= req_data.box_tag;
      end
   end

   // ---------------------------------------------------------------------
   // ABS: divider numerators. |lo - o| < 2^32, so the magnitude fits 32 bits.
   // Parallel slab misses when o < min (lo - o > 0) or o > max (hi - o < 0).
   // ---------------------------------------------------------------------
   function automatic logic [COORD_W-1:0] diff_mag(input logic [COORD_W:0] d);
      logic [COORD_W:0] n;
      n = d[COORD_W] ? (~d + 1'b1) : d;
      return n[COORD_W-1:0];
   endfunction

   logic [NUM_W-1:0] abs_lo_ff [3];
   logic [NUM_W-1:0] abs_hi_ff [3];
   sb_type           sb_in;
   sb_type           sb_ff [DIV_ST+1];

   always_comb begin
      sb_in.tag = cap_tag_ff;
      for (int a = 0; a < 3; a++) begin
         sb_in.neg_lo[a] = cap_lo_ff[a][COORD_W];
         sb_in.neg_hi[a] = cap_hi_ff[a][COORD_W];
         sb_in.pmiss[a]  = (!cap_lo_ff[a][COORD_W] && (cap_lo_ff[a] != '0))
                         || cap_hi_ff[a][COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[S_ABS]) begin
         for (int a = 0; a < 3; a++) begin
            abs_lo_ff[a] <= {diff_mag(cap_lo_ff[a]), FRAC_W'(0)};
            abs_hi_ff[a] <= {diff_mag(cap_hi_ff[a]), FRAC_W'(0)};
         end
         sb_ff[0] <= sb_in;
      end
      // sideband shifts in step with the divider stages
      for (int j = 1; j <= DIV_ST; j++) begin
         if (ready[S_DIV0+j-1]) sb_ff[j] <= sb_ff[j-1];
      end
   end

   // ---------------------------------------------------------------------
   // DIV: six unsigned dividers, one per slab plane. Parallel axes may see
   // a zero divisor; their quotient is never used.
   // ---------------------------------------------------------------------
   logic [NUM_W-1:0] quo_lo [3];
   logic [NUM_W-1:0] quo_hi [3];

   genvar ga;
   for (ga = 0; ga < 3; ga++) begin : g_axis
      rbst_div_pipe #(
         .NUM_W     (NUM_W),
         .DEN_W     (DEN_W),
         .STEP_BITS (DIV_BITS)
      ) u_div_lo (
         .clock (clock),
         .load  (ready[S_DIV0 +: DIV_ST]),
         .num   (abs_lo_ff[ga]),
         .den   (dir_mag_ff[ga]),
         .quo   (quo_lo[ga])
      );

      rbst_div_pipe #(
         .NUM_W     (NUM_W),
         .DEN_W     (DEN_W),
         .STEP_BITS (DIV_BITS)
      ) u_div_hi (
         .clock (clock),
         .load  (ready[S_DIV0 +: DIV_ST]),
         .num   (abs_hi_ff[ga]),
         .den   (dir_mag_ff[ga]),
         .quo   (quo_hi[ga])
      );
   end

   // ---------------------------------------------------------------------
   // SIGN: magnitude quotient with the sign of numerator xor direction,
   // i.e. the quotient truncated toward zero.
   // ---------------------------------------------------------------------
   function automatic dist_type apply_sign(input logic [NUM_W-1:0] q, input logic neg);
      logic [T_W-1:0] q_ext;
      q_ext = {1'b0, q};
      return neg ? T_W'(~q_ext + 1'b1) : q_ext;
   endfunction

   dist_type t_lo_ff [3];
   dist_type t_hi_ff [3];
   sb_type   sign_sb_ff;

   always_ff @(posedge clock) begin
      if (ready[S_SIGN]) begin
         for (int a = 0; a < 3; a++) begin
            t_lo_ff[a] <= apply_sign(quo_lo[a], sb_ff[DIV_ST].neg_lo[a] ^ dir_neg_ff[a]);
            t_hi_ff[a] <= apply_sign(quo_hi[a], sb_ff[DIV_ST].neg_hi[a] ^ dir_neg_ff[a]);
         end
         sign_sb_ff <= sb_ff[DIV_ST];
      end
   end

   // ---------------------------------------------------------------------
   // SWAP: order each slab. A flip means the ray enters through the max
   // face, whose normal points along +axis. The interval starts here as
   // [0, max_distance] with no normal.
   // ---------------------------------------------------------------------
   walk_type swap_in;
   walk_type swap_ff;

   always_comb begin
      swap_in        = '0;
      swap_in.tag    = sign_sb_ff.tag;
      swap_in.hit    = 1'b1;
      swap_in.entry  = '0;
      swap_in.exit_t = T_W'(max_dist_ff);
      swap_in.axis   = AXIS_NONE;
      swap_in.pos    = 1'b0;
      swap_in.pmiss  = sign_sb_ff.pmiss;
      for (int a = 0; a < 3; a++) begin
         swap_in.flip[a]   = t_lo_ff[a] > t_hi_ff[a];
         swap_in.near_t[a] = swap_in.flip[a] ? t_hi_ff[a] : t_lo_ff[a];
         swap_in.far_t[a]  = swap_in.flip[a] ? t_lo_ff[a] : t_hi_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[S_SWAP]) swap_ff <= swap_in;
   end

   // ---------------------------------------------------------------------
   // X, Y, Z: narrow the interval one axis per stage. Entry only moves on a
   // strictly larger near distance, so an origin inside the box keeps entry
   // at 0 and no normal. Once missed, later updates do not matter: a miss
   // is formatted to fixed values.
   // ---------------------------------------------------------------------
   function automatic walk_type axis_step(
      input walk_type          w,
      input logic [AXIS_W-1:0] code,
      input logic              par,
      input dist_type          near_t,
      input dist_type          far_t,
      input logic              flip,
      input logic              pmiss
   );
      walk_type r;
      r = w;
      if (par) begin
         if (pmiss) r.hit = 1'b0;
      end else begin
         if (near_t > r.entry) begin
            r.entry = near_t;
            r.axis  = code;
            r.pos   = flip;
         end
         if (far_t < r.exit_t) r.exit_t = far_t;
         if (r.entry > r.exit_t) r.hit = 1'b0;
      end
      return r;
   endfunction

   walk_type wx_in, wx_ff;
   walk_type wy_in, wy_ff;
   walk_type wz_in;
   rsp_type  rsp_in, rsp_ff;

   assign wx_in = axis_step(swap_ff, AXIS_X, axis_par[0], swap_ff.near_t[0],
                            swap_ff.far_t[0], swap_ff.flip[0], swap_ff.pmiss[0]);
   assign wy_in = axis_step(wx_ff, AXIS_Y, axis_par[1], wx_ff.near_t[1],
                            wx_ff.far_t[1], wx_ff.flip[1], wx_ff.pmiss[1]);
   assign wz_in = axis_step(wy_ff, AXIS_Z, axis_par[2], wy_ff.near_t[2],
                            wy_ff.far_t[2], wy_ff.flip[2], wy_ff.pmiss[2]);

   // on a hit entry <= exit <= max_distance, so it fits the 31-bit field
   always_comb begin
      rsp_in.hit             = wz_in.hit;
      rsp_in.entry_distance  = wz_in.hit ? wz_in.entry[DIST_W-1:0] : '0;
      rsp_in.normal_axis     = wz_in.hit ? wz_in.axis : AXIS_NONE;
      rsp_in.normal_positive = wz_in.hit && wz_in.pos;
      rsp_in.result_tag      = wz_in.tag;
   end

   always_ff @(posedge clock) begin
      if (ready[S_X]) wx_ff  <= wx_in;
      if (ready[S_Y]) wy_ff  <= wy_in;
      if (ready[S_Z]) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/rbst_checker.sv
module rbst_checker
   import rbst_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   logic              in_beat;
   logic              out_beat;
   logic [7:0]        pending_ff;
   logic [7:0]        pending_in;
   logic [DIST_W-1:0] max_dist_ff;

   assign in_beat    = req_valid && !req_stall;
   assign out_beat   = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 8'(in_beat) - 8'(out_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         max_dist_ff <= MAX_DIST_RESET;
      end else begin
         pending_ff <= pending_in;
         if (csr_valid && csr_ready && (csr_index == CSR_MAX_DISTANCE)) begin
            max_dist_ff <= csr_data[DIST_W-1:0];
         end
      end
   end

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // no result without a box in flight
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result beat with no box outstanding");

   // miss carries fixed fields
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         (rsp_data.entry_distance == '0) && (rsp_data.normal_axis == AXIS_NONE)
         && !rsp_data.normal_positive)
      else $error("miss with nonzero distance or normal");

   // a normal exists exactly when the entry distance is positive
   a_hit_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |->
         ((rsp_data.normal_axis == AXIS_NONE) == (rsp_data.entry_distance == '0))
         && ((rsp_data.normal_axis != AXIS_NONE) || !rsp_data.normal_positive))
      else $error("hit normal inconsistent with entry distance");

   // hits stay within the configured range
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> (rsp_data.entry_distance <= max_dist_ff))
      else $error("hit beyond max distance");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);

>>> tb/ray_box_slab_test_test.sv
`timescale 1ns / 1ps

module ray_box_slab_test_test;
   import rbst_pkg::*;

   // accept-to-result depth of the default build (DIV_BITS = 4)
   localparam int PIPE_DEPTH      = 18;
   localparam int RAND_PHASES     = 8;
   localparam int BOXES_PER_PHASE = 106;
   localparam int IDLE_PCT        = 18;
   localparam int QUIET_PHASE     = 3;

   localparam logic signed [COORD_W-1:0] UNIT      = 32'sh0001_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   // an index past the register map; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_NO_SUCH_REG = CSR_IDX_W'(12);
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_INDEX   = {CSR_IDX_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] ORIGIN_REG [3] = '{CSR_ORIGIN_X, CSR_ORIGIN_Y, CSR_ORIGIN_Z};
   localparam logic [CSR_IDX_W-1:0] DIR_REG [3]    = '{CSR_DIR_X, CSR_DIR_Y, CSR_DIR_Z};
   localparam logic [AXIS_W-1:0]    FACE_OF [3]    = '{AXIS_X, AXIS_Y, AXIS_Z};

   typedef enum logic [1:0] {ROW_REG, ROW_BOX, ROW_BOX_KNOWN} row_kind_e;

   // one line of the directed plan: a register write, or a box beat that is
   // either run through the predictor or carries its answer typed in
   typedef struct packed {
      row_kind_e             kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_type               box;
      rsp_type               want;
   } stim_row_t;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // no idling on either side while set
   bit quiet  = 1'b0;
   int errors = 0;

   // verdicts for accepted boxes, oldest first
   rsp_type pending_verdicts[$];

   // shadow copy of the ray registers, at the block's widths
   logic signed [COORD_W-1:0] ray_origin [3];
   logic signed [DIR_W-1:0]   ray_dir [3];
   logic [DIST_W-1:0]         ray_reach;
   logic [THR_W-1:0]          ray_flat_limit;

   ray_box_slab_test uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   task automatic flag_error(input string what);
      errors++;
      // keep the log bounded when everything goes wrong at once
      if (errors <= 200) $display("t=%0t: %s", $time, what);
   endtask

   // Slab test of one box against the shadow ray.
   function automatic rsp_type slab_verdict(input req_type box);
      logic signed [COORD_W-1:0] lo_c [3];
      logic signed [COORD_W-1:0] hi_c [3];
      longint o, d, mag, t_near, t_far, swap, entry, leave;
      bit alive, flip;
      int i;
      rsp_type v;
      lo_c = '{box.box_min_x, box.box_min_y, box.box_min_z};
      hi_c = '{box.box_max_x, box.box_max_y, box.box_max_z};
      entry = 0;
      leave = longint'(ray_reach);
      alive = 1'b1;
      v = '0;
      v.normal_axis = AXIS_NONE;
      v.result_tag = box.box_tag;
      for (i = 0; i < 3 && alive; i++) begin
         o = longint'(ray_origin[i]);
         d = longint'(ray_dir[i]);
         mag = (d < 0) ? -d : d;
         if (d == 0 || mag < longint'(ray_flat_limit)) begin
            // flat axis: no division, origin just has to sit in the slab
            if (o < longint'(lo_c[i]) || o > longint'(hi_c[i])) alive = 1'b0;
         end else begin
            t_near = ((longint'(lo_c[i]) - o) * 65536) / d;
            t_far  = ((longint'(hi_c[i]) - o) * 65536) / d;
            flip = t_near > t_far;
            if (flip) begin
               swap = t_near;
               t_near = t_far;
               t_far = swap;
            end
            if (t_near > entry) begin
               entry = t_near;
               v.normal_axis = FACE_OF[i];
               v.normal_positive = flip;
            end
            if (t_far < leave) leave = t_far;
            if (entry > leave) alive = 1'b0;
         end
      end
      if (alive) begin
         v.hit = 1'b1;
         v.entry_distance = entry[DIST_W-1:0];
      end else begin
         v.hit = 1'b0;
         v.entry_distance = '0;
         v.normal_axis = AXIS_NONE;
         v.normal_positive = 1'b0;
      end
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
      if (v > 64'sh7FFF_FFFF) return COORD_MAX;
      if (v < -64'sh8000_0000) return COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   function automatic req_type mk_box(input logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz,
                                      input logic [TAG_W-1:0] tag);
      req_type b;
      b.box_min_x = lx;
      b.box_min_y = ly;
      b.box_min_z = lz;
      b.box_max_x = hx;
      b.box_max_y = hy;
      b.box_max_z = hz;
      b.box_tag = tag;
      return b;
   endfunction

   function automatic stim_row_t reg_row(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] v);
      stim_row_t r;
      r = '0;
      r.kind = ROW_REG;
      r.reg_index = idx;
      r.reg_value = v;
      return r;
   endfunction

   function automatic stim_row_t checked_row(input req_type box);
      stim_row_t r;
      r = '0;
      r.kind = ROW_BOX;
      r.box = box;
      return r;
   endfunction

   function automatic stim_row_t known_row(input req_type box, input rsp_type want);
      stim_row_t r;
      r = '0;
      r.kind = ROW_BOX_KNOWN;
      r.box = box;
      r.want = want;
      return r;
   endfunction

   // Mostly boxes placed along the current ray, plus boxes around the origin
   // (some with a face through it), inverted boxes and raw noise.
   function automatic req_type random_box();
      logic signed [COORD_W-1:0] lo [3];
      logic signed [COORD_W-1:0] hi [3];
      logic signed [COORD_W-1:0] tmp;
      longint p, half, t;
      int roll, a, i;
      req_type b;
      roll = $urandom_range(99);
      if (roll >= 85) begin
         b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
         return b;
      end
      // distance along the ray: -4 .. 60 units, or 0 for origin-centered boxes
      if (roll >= 60 && roll < 75) t = 0;
      else t = longint'($urandom_range(1 << 22)) - longint'(1 << 18);
      a = $urandom_range(2);
      for (i = 0; i < 3; i++) begin
         p = longint'(ray_origin[i]) + ((longint'(ray_dir[i]) * t) >>> 16);
         half = longint'($urandom_range(1 << 18));
         lo[i] = sat_coord(p - half);
         hi[i] = sat_coord(p + half);
      end
      if (roll >= 60 && roll < 75 && $urandom_range(1)) begin
         if ($urandom_range(1)) lo[a] = ray_origin[a];
         else hi[a] = ray_origin[a];
      end
      if (roll >= 75) begin
         tmp = lo[a];
         lo[a] = hi[a];
         hi[a] = tmp;
      end
      return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 16'($urandom));
   endfunction

   // Drops req_valid and waits for every outstanding verdict to come back.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // csr_valid is left high on return; the next box beat drops it, or the
   // next write reuses it, so it never gets two updates in one step.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ORIGIN_X:           ray_origin[0] = v;
         CSR_ORIGIN_Y:           ray_origin[1] = v;
         CSR_ORIGIN_Z:           ray_origin[2] = v;
         CSR_DIR_X:              ray_dir[0] = v[DIR_W-1:0];
         CSR_DIR_Y:              ray_dir[1] = v[DIR_W-1:0];
         CSR_DIR_Z:              ray_dir[2] = v[DIR_W-1:0];
         CSR_MAX_DISTANCE:       ray_reach = v[DIST_W-1:0];
         CSR_PARALLEL_THRESHOLD: ray_flat_limit = v[THR_W-1:0];
         default: ;
      endcase
   endtask

   // One box beat, with random idle cycles ahead of it. The verdict is taken
   // at the accepting edge, so it sees the ray that the block sees.
   task automatic send_box(input req_type box, input bit typed, input rsp_type want);
      csr_valid <= 1'b0;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= box;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_verdicts.push_back(typed ? want : slab_verdict(box));
   endtask

   // New random ray; bits above each register's width are random too.
   task automatic aim_random_ray();
      logic [CSR_DATA_W-1:0] v, r;
      int roll, i, d;
      for (i = 0; i < 3; i++) begin
         roll = $urandom_range(99);
         if (roll < 70) v = 32'(int'($urandom_range(1 << 25)) - (1 << 24));
         else if (roll < 85) v = $urandom_range(1) ? COORD_MAX : COORD_MIN;
         else v = $urandom;
         csr_write(ORIGIN_REG[i], v);
      end
      for (i = 0; i < 3; i++) begin
         roll = $urandom_range(99);
         if (roll < 20) d = 0;
         else if (roll < 35) d = int'($urandom_range(600)) - 300;
         else if (roll < 85) d = int'($urandom_range(131072)) - 65536;
         else d = $urandom;
         csr_write(DIR_REG[i], {14'($urandom), 18'(d)});
      end
      roll = $urandom_range(99);
      if (roll < 60) r = $urandom_range(1 << 26);
      else if (roll < 80) r = 32'h7FFF_FFFF;
      else if (roll < 90) r = '0;
      else r = $urandom;
      csr_write(CSR_MAX_DISTANCE, {1'($urandom), r[DIST_W-1:0]});
      roll = $urandom_range(99);
      if (roll < 60) r = $urandom_range(512);
      else if (roll < 75) r = '0;
      else if (roll < 85) r = 32'h0000_FFFF;
      else r = $urandom;
      csr_write(CSR_PARALLEL_THRESHOLD, {16'($urandom), r[THR_W-1:0]});
      if ($urandom_range(1))
         csr_write(CSR_IDX_W'($urandom_range(CSR_TOP_INDEX, CSR_PARALLEL_THRESHOLD + 1)), $urandom);
   endtask

   // Result side stalls at random, except in the quiet phase.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Result checker: each accepted beat against the oldest verdict.
   always @(posedge clock) begin : result_check
      rsp_type want;
      string diffs;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            flag_error($sformatf("unexpected result beat, tag %h", rsp_data.result_tag));
         end else begin
            want = pending_verdicts.pop_front();
            diffs = "";
            if (rsp_data.hit !== want.hit) diffs = {diffs, " hit"};
            if (rsp_data.entry_distance !== want.entry_distance) diffs = {diffs, " distance"};
            if (rsp_data.normal_axis !== want.normal_axis) diffs = {diffs, " axis"};
            if (rsp_data.normal_positive !== want.normal_positive) diffs = {diffs, " sign"};
            if (rsp_data.result_tag !== want.result_tag) diffs = {diffs, " tag"};
            if (diffs != "")
               flag_error($sformatf({"box %h, wrong:%s; got hit %b dist %h axis %0d pos %b",
                                     " tag %h, want %b %h %0d %b %h"},
                                    want.result_tag, diffs, rsp_data.hit,
                                    rsp_data.entry_distance, rsp_data.normal_axis,
                                    rsp_data.normal_positive, rsp_data.result_tag, want.hit,
                                    want.entry_distance, want.normal_axis,
                                    want.normal_positive, want.result_tag));
         end
      end
   end

   initial begin : stimulus
      stim_row_t plan[$];
      stim_row_t row;
      int phase, n;

      ray_origin[0] = '0;
      ray_origin[1] = '0;
      ray_origin[2] = '0;
      ray_dir[0] = ONE_Q16;
      ray_dir[1] = '0;
      ray_dir[2] = '0;
      ray_reach = MAX_DIST_RESET;
      ray_flat_limit = THR_RESET;

      // --- default ray: origin 0, along +x, y and z flat ---
      // origin inside: no face
      plan.push_back(known_row(mk_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT, 16'h0000),
                               rsp_type'{1'b1, 31'd0, AXIS_NONE, 1'b0, 16'h0000}));
      // plain hit on the -x face one unit ahead
      plan.push_back(known_row(mk_box(UNIT, -UNIT, -UNIT, 2 * UNIT, UNIT, UNIT, 16'hFFFF),
                               rsp_type'{1'b1, 31'h0001_0000, AXIS_X, 1'b0, 16'hFFFF}));
      // box behind the origin
      plan.push_back(known_row(mk_box(-2 * UNIT, -UNIT, -UNIT, -UNIT, UNIT, UNIT, 16'h0001),
                               rsp_type'{1'b0, 31'd0, AXIS_NONE, 1'b0, 16'h0001}));
      // flat y axis, origin outside the y slab
      plan.push_back(known_row(mk_box(UNIT, UNIT, -UNIT, 2 * UNIT, 2 * UNIT, UNIT, 16'h0002),
                               rsp_type'{1'b0, 31'd0, AXIS_NONE, 1'b0, 16'h0002}));
      // inverted along the ray: swap gives the positive face
      plan.push_back(checked_row(mk_box(2 * UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT, 16'h0003)));
      // inverted on a flat axis always misses
      plan.push_back(known_row(mk_box(-UNIT, UNIT, -UNIT, UNIT, -UNIT, UNIT, 16'h0004),
                               rsp_type'{1'b0, 31'd0, AXIS_NONE, 1'b0, 16'h0004}));
      // whole coordinate range
      plan.push_back(known_row(mk_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX, 16'h5555),
                               rsp_type'{1'b1, 31'd0, AXIS_NONE, 1'b0, 16'h5555}));
      // farthest possible entry, exactly at max distance
      plan.push_back(known_row(mk_box(COORD_MAX, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX, 16'hAAAA),
                               rsp_type'{1'b1, 31'h7FFF_FFFF, AXIS_X, 1'b0, 16'hAAAA}));
      // thin slab at the most negative x
      plan.push_back(known_row(mk_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MIN, COORD_MAX, COORD_MAX, 16'h0008),
                               rsp_type'{1'b0, 31'd0, AXIS_NONE, 1'b0, 16'h0008}));
      // origin on the entry face
      plan.push_back(known_row(mk_box('0, -UNIT, -UNIT, UNIT, UNIT, UNIT, 16'h0009),
                               rsp_type'{1'b1, 31'd0, AXIS_NONE, 1'b0, 16'h0009}));

      // --- extreme origin, out-of-range directions, zero reach, top threshold ---
      plan.push_back(reg_row(CSR_ORIGIN_X, COORD_MAX));
      plan.push_back(reg_row(CSR_ORIGIN_Y, COORD_MIN));
      plan.push_back(reg_row(CSR_ORIGIN_Z, 32'h0001_8000));
      plan.push_back(reg_row(CSR_DIR_X, 32'hFFFF_0000));
      plan.push_back(reg_row(CSR_DIR_Y, 32'h0001_FFFF));
      plan.push_back(reg_row(CSR_DIR_Z, 32'hABC2_0000));
      plan.push_back(reg_row(CSR_MAX_DISTANCE, 32'h0000_0000));
      plan.push_back(reg_row(CSR_PARALLEL_THRESHOLD, 32'h0000_FFFF));
      plan.push_back(checked_row(mk_box(COORD_MIN, COORD_MIN, COORD_MIN,
                                        COORD_MAX, COORD_MAX, COORD_MAX, 16'h0010)));
      plan.push_back(checked_row(mk_box(COORD_MAX, COORD_MIN, 32'sh0001_8000,
                                        COORD_MAX, COORD_MIN, 32'sh0001_8000, 16'h0011)));
      plan.push_back(checked_row(mk_box('0, COORD_MIN, UNIT, COORD_MAX, '0, 2 * UNIT, 16'h0012)));

      // --- diagonal in y/z, x zero with a zero threshold, dropped write ---
      plan.push_back(reg_row(CSR_ORIGIN_X, 32'h0000_0000));
      plan.push_back(reg_row(CSR_ORIGIN_Y, 32'h0000_0000));
      plan.push_back(reg_row(CSR_ORIGIN_Z, 32'h0000_0000));
      plan.push_back(reg_row(CSR_DIR_X, 32'h0000_0000));
      plan.push_back(reg_row(CSR_DIR_Y, 32'h0000_B505));
      plan.push_back(reg_row(CSR_DIR_Z, 32'h0003_4AFB));
      plan.push_back(reg_row(CSR_MAX_DISTANCE, 32'hFFFF_FFFF));
      plan.push_back(reg_row(CSR_PARALLEL_THRESHOLD, 32'h0000_0000));
      plan.push_back(reg_row(CSR_NO_SUCH_REG, 32'hFFFF_FFFF));
      plan.push_back(checked_row(mk_box(-UNIT, UNIT, -3 * UNIT, UNIT, 3 * UNIT, -UNIT, 16'h00FF)));
      // x direction zero: flat even though the threshold is zero
      plan.push_back(known_row(mk_box(UNIT, COORD_MIN, COORD_MIN,
                                      2 * UNIT, COORD_MAX, COORD_MAX, 16'hFF00),
                               rsp_type'{1'b0, 31'd0, AXIS_NONE, 1'b0, 16'hFF00}));
      plan.push_back(checked_row(mk_box(-UNIT, -3 * UNIT, UNIT, UNIT, -UNIT, 3 * UNIT, 16'h0016)));
      // half a unit of reach: the same diagonal box is now out of range
      plan.push_back(reg_row(CSR_MAX_DISTANCE, 32'h0000_8000));
      plan.push_back(checked_row(mk_box(-UNIT, UNIT, -3 * UNIT, UNIT, 3 * UNIT, -UNIT, 16'h0017)));
      plan.push_back(checked_row(mk_box(-UNIT, -UNIT, '0, UNIT, UNIT, UNIT, 16'h0018)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         row = plan[k];
         case (row.kind)
            ROW_REG: begin
               settle_pipeline();
               csr_write(row.reg_index, row.reg_value);
            end
            ROW_BOX: send_box(row.box, 1'b0, '0);
            default: send_box(row.box, 1'b1, row.want);
         endcase
      end

      // random rays, each followed by a run of boxes; one phase without idling
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         settle_pipeline();
         aim_random_ray();
         quiet <= (phase == QUIET_PHASE);
         for (n = 0; n < BOXES_PER_PHASE; n++) send_box(random_box(), 1'b0, '0);
      end

      settle_pipeline();
      // catch stray beats after the last verdict
      repeat (3 * PIPE_DEPTH) @(posedge clock);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("ray_box_slab_test test passed");
      end else begin
         $display("ray_box_slab_test test failed");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #400_000;
      $display("ray_box_slab_test test failed");
      $finish;
   end

endmodule
